@@ rtl/core/zrmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zrmc_pkg
// Shared constants, command codes and types of the zero-run memory compactor.
// ----------------------------------------------------------------------------
package zrmc_pkg;

  // Default sizes of the word memory.
  localparam int unsigned DEPTH_DEF      = 256;
  localparam int unsigned WORD_WIDTH_DEF = 32;

  // Fixed port widths.
  localparam int unsigned USED_W  = 9;
  localparam int unsigned ADDR_W  = 8;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned START_W = 8;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned TOTAL_W = 9;

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [0:0]  REG_USED_WORDS = 1'b0;
  localparam logic [USED_W-1:0] USED_WORDS_RESET = 9'd256;

  // Command codes.
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_COMPACT = 2'd2;
  localparam logic [1:0] CMD_QUERY   = 2'd3;

  // One step of the free run accounting.
  typedef struct packed {
    logic              clr;
    logic              step;
    logic              free;
    logic [USED_W-1:0] pos;
  } scan_ctl_t;

endpackage

@@ rtl/core/zrmc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zrmc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module zrmc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/zrmc_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zrmc_scan
// Free run accounting: counts runs and free words and captures one run.
// ----------------------------------------------------------------------------
module zrmc_scan (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  zrmc_pkg::scan_ctl_t                  ctl_i,
  input  logic [zrmc_pkg::IDX_W-1:0]           run_index_i,
  output logic [zrmc_pkg::USED_W-1:0]          run_count_o,
  output logic [zrmc_pkg::USED_W-1:0]          free_total_o,
  output logic                                 run_found_o,
  output logic [zrmc_pkg::USED_W-1:0]          run_start_o,
  output logic [zrmc_pkg::USED_W-1:0]          run_length_o
);

  localparam int unsigned CW = zrmc_pkg::USED_W;

  logic          in_run_q, in_run_d;
  logic [CW-1:0] cur_q, cur_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] total_q, total_d;
  logic          found_q, found_d;
  logic [CW-1:0] start_q, start_d;
  logic [CW-1:0] len_q, len_d;

  always_comb begin
    in_run_d = in_run_q;
    cur_d    = cur_q;
    count_d  = count_q;
    total_d  = total_q;
    found_d  = found_q;
    start_d  = start_q;
    len_d    = len_q;
    if (ctl_i.clr) begin
      in_run_d = 1'b0;
      cur_d    = '0;
      count_d  = '0;
      total_d  = '0;
      found_d  = 1'b0;
      start_d  = '0;
      len_d    = '0;
    end else if (ctl_i.step) begin
      if (ctl_i.free) begin
        total_d = total_q + 1'b1;
        if (!in_run_q) begin
          in_run_d = 1'b1;
          cur_d    = ctl_i.pos;
        end
      end else if (in_run_q) begin
        // A used word (or the end of the used area) closes the open run.
        if (count_q == CW'(run_index_i)) begin
          found_d = 1'b1;
          start_d = cur_q;
          len_d   = ctl_i.pos - cur_q;
        end
        count_d  = count_q + 1'b1;
        in_run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q <= 1'b0;
      cur_q    <= '0;
      count_q  <= '0;
      total_q  <= '0;
      found_q  <= 1'b0;
      start_q  <= '0;
      len_q    <= '0;
    end else begin
      in_run_q <= in_run_d;
      cur_q    <= cur_d;
      count_q  <= count_d;
      total_q  <= total_d;
      found_q  <= found_d;
      start_q  <= start_d;
      len_q    <= len_d;
    end
  end

  assign run_count_o  = count_q;
  assign free_total_o = total_q;
  assign run_found_o  = found_q;
  assign run_start_o  = start_q;
  assign run_length_o = len_q;

endmodule

@@ rtl/core/zero_run_memory_compactor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_run_memory_compactor
// Word memory whose zero words are free. Writes, reads, compaction and free
// run queries, each reporting run count and free word total.
// ----------------------------------------------------------------------------
// Sequence: every command walks the used words once through the single memory
//   read port (n = words in use); compaction first walks them once more from the
//   top down and then fills the freed low words with zero.
// Throughput: one command at a time; the next is accepted as soon as the
//   sequencer is idle, even while a result still waits in the output register.
// Reset: a clearing pass writes zero to all DEPTH words, one per cycle, with
//   the input stalled; configuration writes are taken meanwhile.
module zero_run_memory_compactor #(
  parameter int unsigned DEPTH      = zrmc_pkg::DEPTH_DEF,
  parameter int unsigned WORD_WIDTH = zrmc_pkg::WORD_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [zrmc_pkg::PADDR_W-1:0]       paddr,
  input  logic [zrmc_pkg::PDATA_W-1:0]       pwdata,
  output logic [zrmc_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready,
  // Command channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         command_i,
  input  logic [zrmc_pkg::ADDR_W-1:0]        address_i,
  input  logic [zrmc_pkg::DATA_W-1:0]        write_data_i,
  input  logic [zrmc_pkg::IDX_W-1:0]         run_index_i,
  // Result channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [zrmc_pkg::DATA_W-1:0]        read_data_o,
  output logic                               run_found_o,
  output logic [zrmc_pkg::START_W-1:0]       run_start_o,
  output logic [zrmc_pkg::LEN_W-1:0]         run_length_o,
  output logic [zrmc_pkg::COUNT_W-1:0]       run_count_o,
  output logic [zrmc_pkg::TOTAL_W-1:0]       free_total_o,
  output logic                               addr_error_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = zrmc_pkg::USED_W;
  localparam int unsigned WW = WORD_WIDTH;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ACCESS = 3'd2;
  localparam logic [2:0] S_RWAIT  = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;
  localparam logic [2:0] S_SCAN   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]                    state_q, state_d;
  logic [AW-1:0]                 clr_q, clr_d;
  logic [CW-1:0]                 used_q;
  logic [1:0]                    cmd_q, cmd_d;
  logic [zrmc_pkg::ADDR_W-1:0]   addr_q, addr_d;
  logic [zrmc_pkg::DATA_W-1:0]   data_q, data_d;
  logic [zrmc_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [zrmc_pkg::DATA_W-1:0]   rd_q, rd_d;
  logic                          err_q, err_d;
  logic [CW-1:0]                 a_q, a_d;
  logic [CW-1:0]                 w_q, w_d;
  logic                          pv_q, pv_d;
  logic [CW-1:0]                 pa_q, pa_d;

  logic                          out_valid_q;
  logic [zrmc_pkg::DATA_W-1:0]   out_rd_q;
  logic                          out_found_q;
  logic [zrmc_pkg::START_W-1:0]  out_start_q;
  logic [zrmc_pkg::LEN_W-1:0]    out_len_q;
  logic [zrmc_pkg::COUNT_W-1:0]  out_count_q;
  logic [zrmc_pkg::TOTAL_W-1:0]  out_total_q;
  logic                          out_err_q;
  logic                          load;

  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [WW-1:0]                 wdata;
  logic [AW-1:0]                 raddr;
  logic [WW-1:0]                 rdata;

  zrmc_pkg::scan_ctl_t           ctl;
  logic [CW-1:0]                 scan_count;
  logic [CW-1:0]                 scan_total;
  logic                          scan_found;
  logic [CW-1:0]                 scan_start;
  logic [CW-1:0]                 scan_len;

  logic [CW-1:0]                 n;
  logic                          addr_ok;
  logic                          cfg_wr;

  // Words in use; a setting above the depth acts as the depth.
  assign n       = (32'(used_q) > 32'(DEPTH)) ? CW'(DEPTH) : used_q;
  assign addr_ok = CW'(addr_q) < n;

  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[2] == zrmc_pkg::REG_USED_WORDS);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == zrmc_pkg::REG_USED_WORDS) ?
                  zrmc_pkg::PDATA_W'(used_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= zrmc_pkg::USED_WORDS_RESET;
    end else if (cfg_wr) begin
      used_q <= pwdata[CW-1:0];
    end
  end

  zrmc_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  zrmc_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .run_index_i  (idx_q),
    .run_count_o  (scan_count),
    .free_total_o (scan_total),
    .run_found_o  (scan_found),
    .run_start_o  (scan_start),
    .run_length_o (scan_len)
  );

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cmd_d    = cmd_q;
    addr_d   = addr_q;
    data_d   = data_q;
    idx_d    = idx_q;
    rd_d     = rd_q;
    err_d    = err_q;
    a_d      = a_q;
    w_d      = w_q;
    pv_d     = pv_q;
    pa_d     = pa_q;
    we       = 1'b0;
    waddr    = clr_q;
    wdata    = '0;
    raddr    = AW'(a_q);
    ctl      = '0;
    ctl.pos  = pa_q;
    load     = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = command_i;
          addr_d  = address_i;
          data_d  = write_data_i;
          idx_d   = run_index_i;
          state_d = S_ACCESS;
        end
      end
      S_ACCESS: begin
        ctl.clr = 1'b1;
        rd_d    = '0;
        err_d   = 1'b0;
        pv_d    = 1'b0;
        a_d     = '0;
        state_d = S_SCAN;
        case (cmd_q)
          zrmc_pkg::CMD_WRITE: begin
            err_d = !addr_ok;
            if (addr_ok) begin
              we    = 1'b1;
              waddr = AW'(addr_q);
              wdata = WW'(data_q);
            end
          end
          zrmc_pkg::CMD_READ: begin
            err_d   = !addr_ok;
            raddr   = AW'(addr_q);
            state_d = S_RWAIT;
          end
          zrmc_pkg::CMD_COMPACT: begin
            a_d     = n;
            w_d     = n;
            state_d = S_CMP;
          end
          default: begin
            state_d = S_SCAN;
          end
        endcase
      end
      S_RWAIT: begin
        rd_d    = err_q ? '0 : zrmc_pkg::DATA_W'(rdata);
        state_d = S_SCAN;
      end
      S_CMP: begin
        // Walk downward; each used word lands at the next slot from the top.
        if (pv_q && (rdata != '0)) begin
          we    = 1'b1;
          waddr = AW'(w_q - 1'b1);
          wdata = rdata;
          w_d   = w_q - 1'b1;
        end
        if (a_q != '0) begin
          raddr = AW'(a_q - 1'b1);
          a_d   = a_q - 1'b1;
          pv_d  = 1'b1;
        end else begin
          pv_d = 1'b0;
          if (!pv_q) begin
            state_d = S_FILL;
          end
        end
      end
      S_FILL: begin
        if (a_q < w_q) begin
          we    = 1'b1;
          waddr = AW'(a_q);
          a_d   = a_q + 1'b1;
        end else begin
          a_d     = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pv_q) begin
          ctl.step = 1'b1;
          ctl.free = (rdata == '0);
          ctl.pos  = pa_q;
        end
        if (a_q < n) begin
          raddr = AW'(a_q);
          pa_d  = a_q;
          a_d   = a_q + 1'b1;
          pv_d  = 1'b1;
        end else begin
          pv_d = 1'b0;
          if (!pv_q) begin
            // The end of the used area closes a run that is still open.
            ctl.step = 1'b1;
            ctl.free = 1'b0;
            ctl.pos  = n;
            state_d  = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      a_q     <= '0;
      w_q     <= '0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      a_q     <= a_d;
      w_q     <= w_d;
      pv_q    <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    addr_q <= addr_d;
    data_q <= data_d;
    idx_q  <= idx_d;
    rd_q   <= rd_d;
    err_q  <= err_d;
    pa_q   <= pa_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_rd_q    <= rd_q;
      out_err_q   <= err_q;
      out_count_q <= zrmc_pkg::COUNT_W'(scan_count);
      out_total_q <= zrmc_pkg::TOTAL_W'(scan_total);
      if (cmd_q == zrmc_pkg::CMD_QUERY) begin
        out_found_q <= scan_found;
        out_start_q <= zrmc_pkg::START_W'(scan_start);
        out_len_q   <= zrmc_pkg::LEN_W'(scan_len);
      end else begin
        out_found_q <= 1'b0;
        out_start_q <= '0;
        out_len_q   <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = out_rd_q;
  assign run_found_o  = out_found_q;
  assign run_start_o  = out_start_q;
  assign run_length_o = out_len_q;
  assign run_count_o  = out_count_q;
  assign free_total_o = out_total_q;
  assign addr_error_o = out_err_q;

  // A new beat only appears after the sequencer finished a command.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside of the done state");

  // Error results come only from reads and writes, never from a query.
  a_err_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> !out_found_q)
    else $error("address error together with a found run");

  // A found run is never empty.
  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_found_q) |-> (out_len_q != '0))
    else $error("found run with zero length");

  // The free word total cannot exceed the words in use.
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (scan_total <= n))
    else $error("free total above used size");

  // A compaction write never lands at or below the word being read.
  a_cmp_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP && pv_q && rdata != '0) |-> (w_q > a_q))
    else $error("compaction write overtakes the read pointer");

endmodule
